@@ rtl/core/text_console_writer_core_assert.svh @@
// assertion macros for the text console writer core
// needs clk and rst in the scope where a macro is used
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define TCW_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the clock cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TCW_ASSERT_ALWAYS(lbl, expr, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/tcw_pkg.sv @@
// shared constants and types for the text console writer core
// no dependencies
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  // cell and reset values
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // control states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer_core.sv @@
// Character-cell console engine. Each input transfer carries a kind in
// s_tuser: put a character (newline moves to the next row), clear the screen,
// or read one cell; every item returns exactly one result transfer with the
// read cell, the cursor after the item and a scroll flag. The screen lives in
// one 2000 x 16 synchronous memory that is swept one cell per cycle. A put or
// newline that stays on screen loads its result when it is accepted; a read
// loads it after the registered memory read, a clear after blanking all 2000
// cells, and a scroll (bottom-row newline or wrap) after a pipelined copy of
// 1920 cells, one flush step and blanking of the 80 bottom-row cells. After
// reset a blanking pass over all 2000 cells runs before the first item is
// taken; configuration writes are taken at any time.
// depends on tcw_pkg and text_console_writer_core_assert.svh
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,    // text_attribute
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,     // char_code [7:0], cell_index [18:8]
  input  wire logic [1:0]  s_tuser,     // kind
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_value [15:0], cursor_col [22:16], cursor_row [27:23], scrolled [28]
  output logic [31:0]      m_tdata
);

  // screen memory
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // control and cursor registers
  state_t            state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              p_valid, p_valid_next;
  logic [ADDR_W-1:0] p_addr, p_addr_next;
  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic              res_rd, res_rd_next;
  logic              res_scr, res_scr_next;
  logic [ATTR_W-1:0] text_attribute;

  // result register load
  logic              out_load;
  logic [CELL_W-1:0] out_value;
  logic              out_scr;

  // input fields
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_index;
  logic              accept;
  logic              out_free;
  logic [ADDR_W-1:0] pos;

  assign kind       = s_tuser;
  assign char_code  = s_tdata[7:0];
  assign cell_index = s_tdata[18:8];
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign accept     = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign pos        = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);

  // memory access, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      p_valid    <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
      res_rd     <= 1'b0;
      res_scr    <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      p_valid    <= p_valid_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      res_rd     <= res_rd_next;
      res_scr    <= res_scr_next;
    end
  end

  // copy pipeline write address
  always_ff @(posedge clk) begin
    p_addr <= p_addr_next;
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, out_scr, cursor_row_next, cursor_col_next, out_value};
    end
  end

  // next state, memory control and result load
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    p_valid_next    = p_valid;
    p_addr_next     = p_addr;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    res_rd_next     = res_rd;
    res_scr_next    = res_scr;
    mem_we          = 1'b0;
    mem_waddr       = cnt;
    mem_wdata       = BLANK_CELL;
    mem_re          = 1'b0;
    mem_raddr       = cell_index;
    out_load        = 1'b0;
    out_value       = '0;
    out_scr         = 1'b0;

    case (state)
      // blank the store after reset
      ST_INIT: begin
        mem_we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // take one item
      ST_IDLE: begin
        if (accept) begin
          res_rd_next  = 1'b0;
          res_scr_next = 1'b0;
          cnt_next     = '0;
          p_valid_next = 1'b0;
          case (kind)
            KIND_PUT: begin
              if (char_code != NEWLINE_CODE) begin
                mem_we    = 1'b1;
                mem_waddr = pos;
                mem_wdata = {text_attribute, char_code};
              end
              if (char_code == NEWLINE_CODE || cursor_col == COL_W'(COLUMNS - 1)) begin
                cursor_col_next = '0;
                if (cursor_row == ROW_W'(ROWS - 1)) begin
                  res_scr_next = 1'b1;
                  state_next   = ST_SCROLL;
                end else begin
                  cursor_row_next = cursor_row + 1'b1;
                  out_load        = 1'b1;
                end
              end else begin
                cursor_col_next = cursor_col + 1'b1;
                out_load        = 1'b1;
              end
            end
            KIND_CLEAR: begin
              cursor_col_next = '0;
              cursor_row_next = '0;
              state_next      = ST_CLEAR;
            end
            KIND_READ: begin
              if (cell_index < ADDR_W'(CELL_COUNT)) begin
                mem_re      = 1'b1;
                res_rd_next = 1'b1;
                state_next  = ST_DONE;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // copy each row up by one, read ahead of write
      ST_SCROLL: begin
        mem_waddr = p_addr;
        mem_wdata = mem_rdata;
        mem_we    = p_valid;
        if (cnt < ADDR_W'(CELL_COUNT - COLUMNS)) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt + ADDR_W'(COLUMNS);
          p_valid_next = 1'b1;
          p_addr_next  = cnt;
          cnt_next     = cnt + 1'b1;
        end else begin
          p_valid_next = 1'b0;
          state_next   = ST_BLANK;
        end
      end

      // blank the bottom row
      ST_BLANK: begin
        mem_we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // blank the whole store
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // hand over the result of a long item
      ST_DONE: begin
        out_value = res_rd ? mem_rdata : '0;
        out_scr   = res_scr;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  `include "text_console_writer_core_assert.svh"

  `TCW_ASSERT_ALWAYS(a_cursor_range, (cursor_col < COL_W'(COLUMNS)) && (cursor_row < ROW_W'(ROWS)), "cursor off screen")
  `TCW_ASSERT_ALWAYS(a_load_when_free, !out_load || out_free, "result register overwritten")
  `TCW_ASSERT_ALWAYS(a_copy_bound, (state != ST_SCROLL) || (cnt <= ADDR_W'(CELL_COUNT - COLUMNS)), "copy sweep overran")
  `TCW_ASSERT_NEXT(a_read_done, accept && (kind == KIND_READ) && (cell_index < ADDR_W'(CELL_COUNT)), (state == ST_DONE) && res_rd, "cell read not completed")

endmodule

`default_nettype wire
